[design/pulse_width_sensor_frame_decoder_defines.svh]
// assertion macros used by the frame decoder checker
`ifndef PULSE_WIDTH_SENSOR_FRAME_DECODER_DEFINES_SVH
`define PULSE_WIDTH_SENSOR_FRAME_DECODER_DEFINES_SVH

// property checked only while out of reset
`define PWSFD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pwsfd check failed");

// property checked at every edge, reset included
`define PWSFD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pwsfd check failed");

`endif

[design/pwsfd_pkg.sv]
// shared types and constants of the pulse width frame decoder
`default_nettype none

package pwsfd_pkg;

    localparam int FRAME_BITS      = 40;
    localparam int BYTE_W          = 8;
    localparam int BYTE_COUNT      = FRAME_BITS / BYTE_W;
    localparam int TIME_W          = 32;
    localparam int TOTAL_W         = 6;
    localparam int IN_DATA_W       = 40;
    localparam int OUT_DATA_W      = 48;

    localparam logic [TIME_W-1:0]  THRESHOLD_RESET = 32'd65000;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX       = 6'd63;
    localparam logic [TOTAL_W-1:0] FRAME_BITS_CNT  = 6'd40;

    // request kinds carried on tuser
    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_EDGE  = 2'd1,
        MODE_READ  = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic              level;
        logic [TIME_W-1:0] edge_time;
    } item_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] window;
        logic [TOTAL_W-1:0]    total;
    } frame_t;

endpackage

`default_nettype wire

[design/pwsfd_in_stage.sv]
// input register for incoming requests
`default_nettype none

module pwsfd_in_stage (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [pwsfd_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic [1:0]                    s_axis_tuser,
    input  wire logic                          take,
    output logic                               item_valid,
    output pwsfd_pkg::item_t                   item
);
    import pwsfd_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // accept when empty or when the held request leaves this cycle
    assign s_axis_tready = !valid_reg || take;
    assign item_valid    = valid_reg;
    assign item          = item_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_reg <= s_axis_tvalid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg.mode      <= mode_t'(s_axis_tuser);
            item_reg.level     <= s_axis_tdata[0];
            item_reg.edge_time <= s_axis_tdata[TIME_W:1];
        end
    end

endmodule

`default_nettype wire

[design/pwsfd_capture.sv]
// pulse timing, bit capture and threshold register
`default_nettype none

module pwsfd_capture (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic [pwsfd_pkg::TIME_W-1:0]  cfg_data,
    input  wire logic                          take,
    input  wire pwsfd_pkg::item_t              item,
    output pwsfd_pkg::frame_t                  frame
);
    import pwsfd_pkg::*;

    logic [TIME_W-1:0]     threshold_reg;
    logic                  high_seen_reg, high_seen_next;
    logic [TIME_W-1:0]     rise_stamp_reg, rise_stamp_next;
    logic [FRAME_BITS-1:0] window_reg, window_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic [TIME_W-1:0]     high_time;
    logic                  bit_value;

    assign frame.window = window_reg;
    assign frame.total  = total_reg;

    // high time wraps with the timestamp
    assign high_time = item.edge_time - rise_stamp_reg;
    assign bit_value = (high_time >= threshold_reg);

    // next state for the request leaving the input register
    always_comb
    begin
        high_seen_next  = high_seen_reg;
        rise_stamp_next = rise_stamp_reg;
        window_next     = window_reg;
        total_next      = total_reg;
        if (take)
        begin
            unique case (item.mode)
                MODE_START:
                begin
                    high_seen_next = 1'b0;
                    window_next    = '0;
                    total_next     = '0;
                end
                MODE_EDGE:
                begin
                    if (item.level)
                    begin
                        rise_stamp_next = item.edge_time;
                        high_seen_next  = 1'b1;
                    end
                    else if (high_seen_reg)
                    begin
                        window_next    = {window_reg[FRAME_BITS-2:0], bit_value};
                        high_seen_next = 1'b0;
                        if (total_reg != TOTAL_MAX)
                        begin
                            total_next = total_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // decoder state and threshold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_RESET;
            high_seen_reg  <= 1'b0;
            rise_stamp_reg <= '0;
            window_reg     <= '0;
            total_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                threshold_reg <= cfg_data;
            end
            high_seen_reg  <= high_seen_next;
            rise_stamp_reg <= rise_stamp_next;
            window_reg     <= window_next;
            total_reg      <= total_next;
        end
    end

endmodule

`default_nettype wire

[design/pwsfd_out_stage.sv]
// frame split, checksum and result register
`default_nettype none

module pwsfd_out_stage (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            load,
    input  wire pwsfd_pkg::frame_t               frame,
    output logic                                 out_free,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [pwsfd_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import pwsfd_pkg::*;

    logic                        valid_reg;
    logic [OUT_DATA_W-1:0]       data_reg;
    logic [OUT_DATA_W-1:0]       data_next;
    logic [BYTE_COUNT*BYTE_W-1:0] bytes_lo_first;
    logic [BYTE_W-1:0]           sum;
    logic                        checksum_ok;
    logic                        frame_short;

    assign out_free      = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

    // bytes msb first, first byte placed lowest
    always_comb
    begin
        for (int k = 0; k < BYTE_COUNT; k++)
        begin
            bytes_lo_first[k*BYTE_W +: BYTE_W] =
                frame.window[FRAME_BITS-BYTE_W-BYTE_W*k +: BYTE_W];
        end
    end

    // checksum over the four data bytes, low 8 bits
    assign sum = bytes_lo_first[0*BYTE_W +: BYTE_W] + bytes_lo_first[1*BYTE_W +: BYTE_W]
               + bytes_lo_first[2*BYTE_W +: BYTE_W] + bytes_lo_first[3*BYTE_W +: BYTE_W];
    assign checksum_ok = (sum == bytes_lo_first[4*BYTE_W +: BYTE_W]);
    assign frame_short = (frame.total < FRAME_BITS_CNT);
    assign data_next   = {frame.total, frame_short, checksum_ok, bytes_lo_first};

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[design/pulse_width_sensor_frame_decoder.sv]
// Pulse width frame decoder top level.
// A read request goes through the input register, then the result register.
// Throughput: one request per cycle; a read waits only while a prior result is held.
// Reset (rst_n low, asynchronous): both stages empty, frame cleared, threshold 65000 ns.
`default_nettype none

module pulse_width_sensor_frame_decoder (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration: bit threshold in ns
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pwsfd_pkg::TIME_W-1:0]      cfg_data,
    // request stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [0] pin_level, [32:1] edge_time_ns, [39:33] zero
    input  wire logic [pwsfd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] mode
    input  wire logic [1:0]                        s_axis_tuser,
    // result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [7:0] humidity_whole, [15:8] humidity_frac, [23:16] temp_whole,
    // [31:24] temp_frac, [39:32] check_byte, [40] checksum_ok,
    // [41] frame_short, [47:42] bits_seen
    output logic [pwsfd_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);
    import pwsfd_pkg::*;

    logic   item_valid;
    item_t  item;
    frame_t frame;
    logic   out_free;
    logic   take;
    logic   load;

    assign cfg_ready = 1'b1;

    // a read leaves the input register only when the result register is free
    assign take = item_valid && ((item.mode != MODE_READ) || out_free);
    assign load = take && (item.mode == MODE_READ);

    pwsfd_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .take          (take),
        .item_valid    (item_valid),
        .item          (item)
    );

    pwsfd_capture u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .take      (take),
        .item      (item),
        .frame     (frame)
    );

    pwsfd_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .frame         (frame),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

[design/pwsfd_checker.sv]
// port level checks of the frame decoder, bound to the top level
`default_nettype none

`include "pulse_width_sensor_frame_decoder_defines.svh"

module pwsfd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata
);
    import pwsfd_pkg::*;

    logic       read_accept;
    logic [7:0] byte_sum;

    assign read_accept = s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_READ);
    assign byte_sum    = m_axis_tdata[7:0] + m_axis_tdata[15:8]
                       + m_axis_tdata[23:16] + m_axis_tdata[31:24];

    // no result while in reset
    `PWSFD_ASSERT_ALWAYS(a_no_result_in_reset, clk, !rst_n |-> !m_axis_tvalid)

    // held result stays put
    `PWSFD_ASSERT(a_result_held, clk, rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

    // a new result follows an accepted read
    `PWSFD_ASSERT(a_result_from_read, clk, rst_n, $rose(m_axis_tvalid) |-> $past(read_accept, 2))

    // checksum flag matches the bytes shown
    `PWSFD_ASSERT(a_checksum_flag, clk, rst_n,
        m_axis_tvalid |-> (m_axis_tdata[40] == (byte_sum == m_axis_tdata[39:32])))

    // short flag matches the bit count
    `PWSFD_ASSERT(a_short_flag, clk, rst_n,
        m_axis_tvalid |-> (m_axis_tdata[41] == (m_axis_tdata[47:42] < 6'd40)))

endmodule

bind pulse_width_sensor_frame_decoder pwsfd_checker u_pwsfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
